>>> rtl/core/assert_macros.svh
// Assertion macros shared by the decoder RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("%m: assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/afc_pkg.sv
// Shared types and constants for the AFC ADPCM frame decoder.
`timescale 1ns / 1ps

package afc_pkg;

	// Coefficient table geometry.
	localparam int COEF_PAIRS = 16;
	localparam int COEF_IDX_W = $clog2(COEF_PAIRS);

	// Command codes of the input channel.
	localparam logic [1:0] CMD_LOAD_COEF  = 2'd0;
	localparam logic [1:0] CMD_FRAME_BYTE = 2'd1;
	localparam logic [1:0] CMD_SET_HIST   = 2'd2;

	// Frame lengths in bytes, header included.
	localparam logic [3:0] FRAME_LEN_4BIT = 4'd9;
	localparam logic [3:0] FRAME_LEN_2BIT = 4'd5;

	// Index of the last sample of a byte in each mode.
	localparam logic [1:0] LAST_K_4BIT = 2'd1;
	localparam logic [1:0] LAST_K_2BIT = 2'd3;

	// Code alignment and accumulator scaling.
	localparam int SHIFT_4BIT = 11;
	localparam int SHIFT_2BIT = 13;
	localparam int ACC_SHIFT  = 11;
	localparam int ACC_W      = 34;

	// Saturation limits.
	localparam logic signed [15:0] PCM_MAX = 16'sh7fff;
	localparam logic signed [15:0] PCM_MIN = 16'sh8000;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		OP_SET_HIST,
		OP_DATA
	} op_kind_t;

	// One queued operation. For OP_SET_HIST, word_a and word_b carry the
	// newest and older history samples; for OP_DATA, the newer and older
	// coefficients of the frame.
	typedef struct packed {
		op_kind_t          kind;
		logic [7:0]        data_byte;
		logic [3:0]        scale;
		logic signed [15:0] word_a;
		logic signed [15:0] word_b;
		logic              two_bit;
		logic              frame_end;
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_ACC
	} back_state_t;

endpackage

>>> rtl/core/afc_ifs.sv
// Channel interfaces of the AFC ADPCM frame decoder.
`timescale 1ns / 1ps

// Command and frame byte channel.
interface afc_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic [7:0]         data_byte;
	logic [3:0]         coef_slot;
	logic signed [15:0] coef_newer;
	logic signed [15:0] coef_older;
	logic signed [15:0] history_newest;
	logic signed [15:0] history_older;

	modport source (
		output valid, cmd, data_byte, coef_slot, coef_newer, coef_older,
			history_newest, history_older,
		input ready
	);
	modport sink (
		input valid, cmd, data_byte, coef_slot, coef_newer, coef_older,
			history_newest, history_older,
		output ready
	);
endinterface

// Decoded sample channel.
interface afc_pcm_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pcm_sample;
	logic               last_of_byte;
	logic               frame_end;

	modport source (output valid, pcm_sample, last_of_byte, frame_end, input ready);
	modport sink (input valid, pcm_sample, last_of_byte, frame_end, output ready);
endinterface

// Mode register write channel.
interface afc_cfg_if;
	logic valid;
	logic ready;
	logic two_bit_mode;

	modport source (output valid, two_bit_mode, input ready);
	modport sink (input valid, two_bit_mode, output ready);
endinterface

>>> rtl/core/afc_front.sv
// Front end: accepts commands, tracks frame position and coefficients, queues work.
`timescale 1ns / 1ps

module afc_front (
	input  logic          clk,
	input  logic          arst_n,
	afc_cfg_if.sink       cfg,
	afc_cmd_if.sink       cmd_ch,
	input  logic          q_full,
	output logic          q_push,
	output afc_pkg::op_t  q_data
);

	logic                             two_bit_mode_q;
	logic [3:0]                       byte_pos_q;
	logic [3:0]                       frame_scale_q;
	logic [afc_pkg::COEF_IDX_W-1:0]   frame_coef_index_q;
	logic [31:0]                      coef_table_q [afc_pkg::COEF_PAIRS];

	logic       accept;
	logic       is_header;
	logic [3:0] frame_len;
	logic       ends;
	logic       push_sel;
	logic [31:0] coef_pair;

	// The mode register is always writable.
	assign cfg.ready = 1'b1;

	// Commands stall only when the queue has no room.
	assign cmd_ch.ready = !q_full;
	assign accept       = cmd_ch.valid && cmd_ch.ready;

	// Frame position decode.
	assign is_header = (byte_pos_q == 4'd0);
	assign frame_len = two_bit_mode_q ? afc_pkg::FRAME_LEN_2BIT : afc_pkg::FRAME_LEN_4BIT;
	assign ends      = ({1'b0, byte_pos_q} + 5'd1) >= {1'b0, frame_len};
	assign coef_pair = coef_table_q[frame_coef_index_q];

	// Classify the command and build the queued operation.
	always_comb begin
		push_sel = 1'b0;
		q_data.kind      = afc_pkg::OP_DATA;
		q_data.data_byte = cmd_ch.data_byte;
		q_data.scale     = frame_scale_q;
		q_data.word_a    = coef_pair[31:16];
		q_data.word_b    = coef_pair[15:0];
		q_data.two_bit   = two_bit_mode_q;
		q_data.frame_end = ends;
		case (cmd_ch.cmd)
			afc_pkg::CMD_SET_HIST: begin
				push_sel      = 1'b1;
				q_data.kind   = afc_pkg::OP_SET_HIST;
				q_data.word_a = cmd_ch.history_newest;
				q_data.word_b = cmd_ch.history_older;
			end
			afc_pkg::CMD_FRAME_BYTE: begin
				push_sel = !is_header;
			end
			default: begin
				push_sel = 1'b0;
			end
		endcase
	end

	assign q_push = accept && push_sel;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_bit_mode_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			two_bit_mode_q <= cfg.two_bit_mode;
		end
	end

	// Frame header state and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q         <= 4'd0;
			frame_scale_q      <= 4'd0;
			frame_coef_index_q <= '0;
		end else if (accept) begin
			case (cmd_ch.cmd)
				afc_pkg::CMD_SET_HIST: begin
					byte_pos_q <= 4'd0;
				end
				afc_pkg::CMD_FRAME_BYTE: begin
					if (is_header) begin
						frame_scale_q      <= cmd_ch.data_byte[7:4];
						frame_coef_index_q <= cmd_ch.data_byte[afc_pkg::COEF_IDX_W-1:0];
						byte_pos_q         <= 4'd1;
					end else if (ends) begin
						byte_pos_q <= 4'd0;
					end else begin
						byte_pos_q <= byte_pos_q + 4'd1;
					end
				end
				default: begin
					byte_pos_q <= byte_pos_q;
				end
			endcase
		end
	end

	// Coefficient pairs, newer in the high half.
	always_ff @(posedge clk) begin
		if (accept && (cmd_ch.cmd == afc_pkg::CMD_LOAD_COEF)) begin
			coef_table_q[cmd_ch.coef_slot[afc_pkg::COEF_IDX_W-1:0]] <=
				{cmd_ch.coef_newer, cmd_ch.coef_older};
		end
	end

endmodule

>>> rtl/core/afc_queue.sv
// Short operation queue between the front end and the sample engine.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module afc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  afc_pkg::op_t  push_data,
	input  logic          pop,
	output logic          full,
	output logic          nonempty,
	output afc_pkg::op_t  head
);

	afc_pkg::op_t                  entries_q [afc_pkg::QUEUE_DEPTH];
	logic [afc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [afc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [afc_pkg::QCNT_W-1:0]    count_q;

	localparam logic [afc_pkg::QPTR_W-1:0] PTR_LAST = afc_pkg::QPTR_W'(afc_pkg::QUEUE_DEPTH - 1);
	localparam logic [afc_pkg::QCNT_W-1:0] CNT_FULL = afc_pkg::QCNT_W'(afc_pkg::QUEUE_DEPTH);

	assign full     = (count_q == CNT_FULL);
	assign nonempty = (count_q != '0);
	assign head     = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_no_push_full, clk, arst_n, !(push && full && !pop))
	`ASSERT_ALWAYS(a_no_pop_empty, clk, arst_n, !(pop && !nonempty))
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_FULL)

endmodule

>>> rtl/core/afc_back.sv
// Sample engine: applies queued history loads and expands each queued byte into samples through a two-phase MAC.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module afc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  afc_pkg::op_t  q_head,
	output logic          q_pop,
	afc_pcm_if.source     pcm_ch
);

	afc_pkg::back_state_t state_q, state_d;

	afc_pkg::op_t        op_q;
	logic [1:0]          k_q;
	logic signed [15:0]  hist_n_q;
	logic signed [15:0]  hist_o_q;
	logic signed [31:0]  p_new_s1;
	logic signed [31:0]  p_old_s1;
	logic signed [29:0]  term_s1;

	logic                out_valid_q;
	logic signed [15:0]  pcm_q;
	logic                last_of_byte_q;
	logic                frame_end_q;

	logic                out_free;
	logic [1:0]          last_k;
	logic                is_last;
	logic                start_op;
	logic                load_hist;
	logic                do_mul;
	logic                emit;

	logic [7:0]          byte_2b;
	logic [7:0]          byte_4b;
	logic signed [14:0]  code_shifted;
	logic signed [29:0]  term;
	logic signed [afc_pkg::ACC_W-1:0] acc_sum;
	logic signed [afc_pkg::ACC_W-1:0] acc_shr;
	logic signed [15:0]  sample;

	assign out_free = !out_valid_q || pcm_ch.ready;
	assign last_k   = op_q.two_bit ? afc_pkg::LAST_K_2BIT : afc_pkg::LAST_K_4BIT;
	assign is_last  = (k_q == last_k);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			afc_pkg::BK_IDLE: begin
				if (q_nonempty && (q_head.kind == afc_pkg::OP_DATA)) begin
					state_d = afc_pkg::BK_MUL;
				end
			end
			afc_pkg::BK_MUL: begin
				state_d = afc_pkg::BK_ACC;
			end
			afc_pkg::BK_ACC: begin
				if (out_free) begin
					state_d = is_last ? afc_pkg::BK_IDLE : afc_pkg::BK_MUL;
				end
			end
			default: begin
				state_d = afc_pkg::BK_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		q_pop     = 1'b0;
		start_op  = 1'b0;
		load_hist = 1'b0;
		do_mul    = 1'b0;
		emit      = 1'b0;
		case (state_q)
			afc_pkg::BK_IDLE: begin
				q_pop     = q_nonempty;
				start_op  = q_nonempty && (q_head.kind == afc_pkg::OP_DATA);
				load_hist = q_nonempty && (q_head.kind == afc_pkg::OP_SET_HIST);
			end
			afc_pkg::BK_MUL: begin
				do_mul = 1'b1;
			end
			afc_pkg::BK_ACC: begin
				emit = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// Code of the current sample, high bits of the byte first.
	assign byte_2b = op_q.data_byte << {k_q, 1'b0};
	assign byte_4b = op_q.data_byte << {k_q[0], 2'b00};
	assign code_shifted = op_q.two_bit ?
		{byte_2b[7:6], {afc_pkg::SHIFT_2BIT{1'b0}}} :
		{byte_4b[7:4], {afc_pkg::SHIFT_4BIT{1'b0}}};
	assign term = 30'(code_shifted) <<< op_q.scale;

	// Sum, arithmetic shift and saturation.
	assign acc_sum = afc_pkg::ACC_W'(p_new_s1) + afc_pkg::ACC_W'(p_old_s1)
		+ afc_pkg::ACC_W'(term_s1);
	assign acc_shr = acc_sum >>> afc_pkg::ACC_SHIFT;
	always_comb begin
		if (acc_shr[afc_pkg::ACC_W-1:15] == '0 || acc_shr[afc_pkg::ACC_W-1:15] == '1) begin
			sample = acc_shr[15:0];
		end else if (acc_shr[afc_pkg::ACC_W-1]) begin
			sample = afc_pkg::PCM_MIN;
		end else begin
			sample = afc_pkg::PCM_MAX;
		end
	end

	// Control registers and history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= afc_pkg::BK_IDLE;
			k_q      <= 2'd0;
			hist_n_q <= 16'sd0;
			hist_o_q <= 16'sd0;
		end else begin
			state_q <= state_d;
			if (start_op) begin
				k_q <= 2'd0;
			end else if (emit) begin
				k_q <= k_q + 2'd1;
			end
			if (load_hist) begin
				hist_n_q <= q_head.word_a;
				hist_o_q <= q_head.word_b;
			end else if (emit) begin
				hist_n_q <= sample;
				hist_o_q <= hist_n_q;
			end
		end
	end

	// Operation and product registers.
	always_ff @(posedge clk) begin
		if (start_op) begin
			op_q <= q_head;
		end
		if (do_mul) begin
			p_new_s1 <= hist_n_q * op_q.word_a;
			p_old_s1 <= hist_o_q * op_q.word_b;
			term_s1  <= term;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pcm_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pcm_q          <= sample;
			last_of_byte_q <= is_last;
			frame_end_q    <= is_last && op_q.frame_end;
		end
	end

	assign pcm_ch.valid        = out_valid_q;
	assign pcm_ch.pcm_sample   = pcm_q;
	assign pcm_ch.last_of_byte = last_of_byte_q;
	assign pcm_ch.frame_end    = frame_end_q;

	`ASSERT_NEXT(a_stall_holds_hist, clk, arst_n, (state_q == afc_pkg::BK_ACC) && !out_free, $stable(hist_n_q) && (state_q == afc_pkg::BK_ACC))
	`ASSERT_IMPLIES(a_frame_end_last, clk, arst_n, out_valid_q && frame_end_q, last_of_byte_q)
	`ASSERT_IMPLIES(a_k_in_range, clk, arst_n, state_q != afc_pkg::BK_IDLE, k_q <= last_k)

endmodule

>>> rtl/core/afc_adpcm_frame_decoder.sv
// Top level of the AFC ADPCM frame decoder.
//
//   Channel  Role   Carries
//   cfg      sink   two_bit_mode register write
//   cmd_ch   sink   cmd, data_byte, coef_slot, coef_newer/older, history_newest/older
//   pcm_ch   source pcm_sample, last_of_byte, frame_end
//
// Coefficient loads, headers and unused commands are handled in the front end and not queued.
// A data byte leaves the queue, then each of its samples takes a multiply phase and an
// accumulate phase in the shared multiply-accumulate, holding in the accumulate phase
// while the sample sink stalls; a history load is applied as it leaves the queue.
// A two-entry queue lets the front accept commands while the engine works or stalls.
// Reset clears history, frame position and mode; coefficient pairs are unset.
`timescale 1ns / 1ps

module afc_adpcm_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	afc_cfg_if.sink    cfg,
	afc_cmd_if.sink    cmd_ch,
	afc_pcm_if.source  pcm_ch
);

	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_nonempty;
	afc_pkg::op_t  q_in;
	afc_pkg::op_t  q_head;

	// Command classification and frame tracking.
	afc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd_ch (cmd_ch),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_in)
	);

	// Decoupling queue.
	afc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	// Sample engine.
	afc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.pcm_ch     (pcm_ch)
	);

endmodule
